FILE: src/ddo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ddo_pkg;

	// multiplier operand and product widths
	localparam int MA_W = 40;
	localparam int MB_W = 34;
	localparam int MP_W = MA_W + MB_W;

	// register indexes
	localparam logic [1:0] REG_MPT = 2'd0;
	localparam logic [1:0] REG_IWB = 2'd1;

	localparam logic [31:0] MPT_RESET = 32'd7906071;
	localparam logic [23:0] IWB_RESET = 24'd65536;

	// angle constants, Q.20 radians
	localparam logic signed [24:0] TWO_PI_Q20  = 25'sd6588397;
	localparam logic signed [24:0] PI_Q20      = 25'sd3294199;
	localparam logic signed [24:0] HALF_PI_Q20 = 25'sd1647099;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL1, ST_MUL2, ST_MOD, ST_FOLD, ST_CORD, ST_MUL3, ST_PUB
	} ddo_state_t;

	typedef struct packed {
		logic        ovf;
		logic [31:0] val;
	} sat32_t;

	// clamp to int32 and flag
	function automatic sat32_t sat32(input logic signed [63:0] v);
		sat32_t r;
		r.ovf = 1'b0;
		r.val = v[31:0];
		if (v > 64'sd2147483647) begin
			r.ovf = 1'b1;
			r.val = 32'h7fffffff;
		end else if (v < -64'sd2147483648) begin
			r.ovf = 1'b1;
			r.val = 32'h80000000;
		end
		return r;
	endfunction

	// arctangent of 2^-i, Q.30
	function automatic logic [31:0] atan_q30(input logic [4:0] i);
		logic [31:0] r;
		unique case (i)
			5'd0:  r = 32'd843314856;
			5'd1:  r = 32'd497837829;
			5'd2:  r = 32'd263043836;
			5'd3:  r = 32'd133525158;
			5'd4:  r = 32'd67021686;
			5'd5:  r = 32'd33543515;
			5'd6:  r = 32'd16775850;
			5'd7:  r = 32'd8388437;
			5'd8:  r = 32'd4194282;
			5'd9:  r = 32'd2097149;
			5'd10: r = 32'd1048575;
			5'd11: r = 32'd524287;
			5'd12: r = 32'd262143;
			5'd13: r = 32'd131071;
			5'd14: r = 32'd65535;
			5'd15: r = 32'd32767;
			5'd16: r = 32'd16383;
			5'd17: r = 32'd8191;
			5'd18: r = 32'd4095;
			5'd19: r = 32'd2047;
			5'd20: r = 32'd1023;
			5'd21: r = 32'd511;
			5'd22: r = 32'd255;
			5'd23: r = 32'd127;
			5'd24: r = 32'd63;
			5'd25: r = 32'd31;
			5'd26: r = 32'd15;
			5'd27: r = 32'd8;
			5'd28: r = 32'd4;
			5'd29: r = 32'd2;
			5'd30: r = 32'd1;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: src/ddo_smul.sv
`timescale 1ns / 1ps
`default_nettype none
module ddo_smul
	import ddo_pkg::*;
#(
	parameter int AW = 40,
	parameter int BW = 34
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	input  wire logic signed [AW-1:0]    a,
	input  wire logic signed [BW-1:0]    b,
	output logic                         done,
	output logic signed [AW+BW-1:0]      prod
);
	localparam int PW = AW + BW;
	localparam int CW = $clog2(BW + 1);

	logic signed [PW-1:0] mcand_q;
	logic signed [PW-1:0] acc_q;
	logic [BW-1:0]        mplier_q;
	logic [CW-1:0]        cnt_q;
	logic                 run_q;
	logic                 done_q;
	logic signed [PW-1:0] term;

	// one multiplier bit per cycle; the sign bit weighs negative
	assign term = mplier_q[0] ? mcand_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(BW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q  <= {{BW{a[AW-1]}}, a};
			mplier_q <= b;
			acc_q    <= '0;
		end else if (run_q) begin
			mcand_q  <= mcand_q <<< 1;
			mplier_q <= mplier_q >> 1;
			if (cnt_q == CW'(BW - 1))
				acc_q <= acc_q - term;
			else
				acc_q <= acc_q + term;
		end
	end

	assign done = done_q;
	assign prod = acc_q;
endmodule
`default_nettype wire

FILE: src/differential_drive_odometry.sv
`timescale 1ns / 1ps
`default_nettype none
// Each accepted item runs through two bit-serial multiply passes, 10 remainder steps,
// a fold step, the CORDIC rotations, a third multiply pass and a publish step.
// A new item is taken only in the idle state; the first item after reset only primes the counts.
// The next item is taken while a pose still waits in the output register.
// Reset (arst_n low, asynchronous) clears pose, stored counts and the flag,
// and loads the register reset values.
module differential_drive_odometry
	import ddo_pkg::*;
#(
	parameter int CORDIC_STEPS = 24
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cfg_we,
	input  wire [1:0]         cfg_index,
	input  wire [31:0]        cfg_data,
	input  wire               in_valid,
	output logic              in_stall,
	input  wire [31:0]        sample_time,
	input  wire signed [31:0] front_left_count,
	input  wire signed [31:0] front_right_count,
	input  wire signed [31:0] rear_left_count,
	input  wire signed [31:0] rear_right_count,
	output logic              out_valid,
	input  wire               out_stall,
	output logic [31:0]        pose_time,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] heading,
	output logic               saturated
);
	localparam int IW = $clog2(CORDIC_STEPS + 1);

	ddo_state_t state_q, state_d;

	logic [31:0] mpt_q;
	logic [23:0] iwb_q;
	logic [31:0] prev_fl_q, prev_fr_q, prev_rl_q, prev_rr_q;
	logic        have_prev_q;
	logic signed [31:0] acc_x_q, acc_y_q, acc_h_q;
	logic        sticky_q;
	logic [31:0] time_q;
	logic signed [33:0] dc_q;
	logic signed [31:0] dth_q;
	logic [32:0] rem_q;
	logic        mneg_q;
	logic [3:0]  k_q;
	logic        cneg_q;
	logic signed [33:0] x_q, y_q, z_q;
	logic [IW-1:0] i_q;
	logic        ovalid_q;
	logic [31:0] otime_q;
	logic signed [31:0] ox_q, oy_q, oh_q;
	logic        osat_q;

	logic accept, first;
	logic m0_start, m1_start;
	logic signed [MA_W-1:0] m0_a, m1_a;
	logic signed [MB_W-1:0] m0_b, m1_b;
	logic m0_done, m1_done;
	logic signed [MP_W-1:0] m0_p, m1_p;

	// side tick averages, truncated toward zero
	logic [31:0] d_fl, d_fr, d_rl, d_rr;
	logic signed [32:0] sum_l, sum_r, rnd_l, rnd_r;
	logic signed [31:0] ticks_l, ticks_r;

	assign d_fl  = front_left_count - prev_fl_q;
	assign d_fr  = front_right_count - prev_fr_q;
	assign d_rl  = rear_left_count - prev_rl_q;
	assign d_rr  = rear_right_count - prev_rr_q;
	assign sum_l = $signed({d_fl[31], d_fl}) + $signed({d_rl[31], d_rl});
	assign sum_r = $signed({d_fr[31], d_fr}) + $signed({d_rr[31], d_rr});
	assign rnd_l = sum_l + $signed({32'd0, sum_l[32]});
	assign rnd_r = sum_r + $signed({32'd0, sum_r[32]});
	assign ticks_l = rnd_l[32:1];
	assign ticks_r = rnd_r[32:1];

	// side metres, centre distance and wheel difference
	logic signed [MP_W-1:0] rp_l, rp_r;
	logic signed [47:0] m_l, m_r, dc_full;
	logic signed [48:0] sum_m, diff_m;
	logic signed [33:0] dc_sat;
	logic signed [39:0] diff_sat;
	logic dc_ovf, diff_ovf;

	assign rp_l  = m0_p + MP_W'(32768);
	assign rp_r  = m1_p + MP_W'(32768);
	assign m_l   = rp_l[63:16];
	assign m_r   = rp_r[63:16];
	assign sum_m = {m_l[47], m_l} + {m_r[47], m_r};
	assign diff_m = {m_r[47], m_r} - {m_l[47], m_l};
	assign dc_full = sum_m[48:1];

	always_comb begin
		dc_ovf = 1'b1;
		if (dc_full > 48'sd4294967296)
			dc_sat = 34'sd4294967296;
		else if (dc_full < -48'sd4294967296)
			dc_sat = -34'sd4294967296;
		else begin
			dc_sat = dc_full[33:0];
			dc_ovf = 1'b0;
		end
		diff_ovf = 1'b1;
		if (diff_m > 49'sd274877906944)
			diff_sat = 40'sd274877906944;
		else if (diff_m < -49'sd274877906944)
			diff_sat = -40'sd274877906944;
		else begin
			diff_sat = diff_m[39:0];
			diff_ovf = 1'b0;
		end
	end

	// heading change and mid-step angle
	logic signed [MP_W-1:0] rp_t;
	logic signed [61:0] dth_full;
	sat32_t dth_s;
	logic signed [32:0] mid;

	assign rp_t     = m0_p + MP_W'(2048);
	assign dth_full = rp_t[73:12];
	assign dth_s    = sat32(64'(dth_full));
	assign mid      = {acc_h_q[31], acc_h_q} + {{2{dth_s.val[31]}}, dth_s.val[31:1]};

	// remainder of 2 pi, one binary digit of the quotient per cycle
	logic [32:0] sub_k;
	assign sub_k = {8'd0, TWO_PI_Q20} << k_q;

	// fold into [-pi/2, pi/2]
	logic signed [24:0] r0, r1, r2;
	logic fneg;
	always_comb begin
		r0 = mneg_q ? -$signed({2'b0, rem_q[22:0]}) : $signed({2'b0, rem_q[22:0]});
		r1 = r0;
		if (r0 > PI_Q20)
			r1 = r0 - TWO_PI_Q20;
		else if (r0 < -PI_Q20)
			r1 = r0 + TWO_PI_Q20;
		fneg = 1'b0;
		r2 = r1;
		if (r1 > HALF_PI_Q20) begin
			r2 = r1 - PI_Q20;
			fneg = 1'b1;
		end else if (r1 < -HALF_PI_Q20) begin
			r2 = r1 + PI_Q20;
			fneg = 1'b1;
		end
	end

	// one CORDIC rotation per cycle, then the vector is handed over to the multipliers
	logic signed [33:0] xs, ys, at;
	logic last_step;
	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign at = $signed({2'b0, atan_q30(5'(i_q))});
	assign last_step = (i_q == IW'(CORDIC_STEPS));

	// position steps and accumulator updates
	logic signed [MP_W-1:0] rp_x, rp_y;
	logic signed [43:0] dx, dy;
	sat32_t nx, ny, nh;
	assign rp_x = m0_p + MP_W'(536870912);
	assign rp_y = m1_p + MP_W'(536870912);
	assign dx = rp_x[73:30];
	assign dy = rp_y[73:30];
	assign nx = sat32(64'(acc_x_q) + 64'(dx));
	assign ny = sat32(64'(acc_y_q) + 64'(dy));
	assign nh = sat32(64'(acc_h_q) + 64'(dth_q));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept && have_prev_q) state_d = ST_MUL1;
			ST_MUL1: if (m0_done) state_d = ST_MUL2;
			ST_MUL2: if (m0_done) state_d = ST_MOD;
			ST_MOD:  if (k_q == 4'd0) state_d = ST_FOLD;
			ST_FOLD: state_d = ST_CORD;
			ST_CORD: if (last_step) state_d = ST_MUL3;
			ST_MUL3: if (m0_done && m1_done) state_d = ST_PUB;
			ST_PUB:  if (!ovalid_q || !out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// handshake and multiplier control
	always_comb begin
		in_stall = (state_q != ST_IDLE);
		accept   = in_valid && !in_stall;
		first    = accept && !have_prev_q;
		m0_start = 1'b0;
		m0_a     = 40'(dc_q);
		m0_b     = (cneg_q ? -x_q : x_q);
		m1_a     = 40'(dc_q);
		m1_b     = (cneg_q ? -y_q : y_q);
		unique case (state_q)
			ST_IDLE: begin
				m0_start = accept && have_prev_q;
				m0_a = 40'(ticks_l);
				m1_a = 40'(ticks_r);
				m0_b = $signed({2'b0, mpt_q});
				m1_b = $signed({2'b0, mpt_q});
			end
			ST_MUL1: begin
				m0_start = m0_done;
				m0_a = diff_sat;
				m0_b = $signed({10'd0, iwb_q});
			end
			ST_CORD: m0_start = last_step;
			default: m0_start = 1'b0;
		endcase
		m1_start = m0_start && (state_q != ST_MUL1);
	end

	ddo_smul #(.AW(MA_W), .BW(MB_W)) u_mul0 (
		.clk(clk), .arst_n(arst_n), .start(m0_start), .a(m0_a), .b(m0_b),
		.done(m0_done), .prod(m0_p)
	);

	ddo_smul #(.AW(MA_W), .BW(MB_W)) u_mul1 (
		.clk(clk), .arst_n(arst_n), .start(m1_start), .a(m1_a), .b(m1_b),
		.done(m1_done), .prod(m1_p)
	);

	// control state, pose and registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mpt_q       <= MPT_RESET;
			iwb_q       <= IWB_RESET;
			prev_fl_q   <= '0;
			prev_fr_q   <= '0;
			prev_rl_q   <= '0;
			prev_rr_q   <= '0;
			have_prev_q <= 1'b0;
			acc_x_q     <= '0;
			acc_y_q     <= '0;
			acc_h_q     <= '0;
			sticky_q    <= 1'b0;
			ovalid_q    <= 1'b0;
			osat_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_MPT: mpt_q <= cfg_data;
					REG_IWB: iwb_q <= cfg_data[23:0];
					default: ;
				endcase
			end
			if (accept) begin
				prev_fl_q   <= front_left_count;
				prev_fr_q   <= front_right_count;
				prev_rl_q   <= rear_left_count;
				prev_rr_q   <= rear_right_count;
				have_prev_q <= 1'b1;
			end
			if (state_q == ST_MUL1 && m0_done && (dc_ovf || diff_ovf))
				sticky_q <= 1'b1;
			if (state_q == ST_MUL2 && m0_done && dth_s.ovf)
				sticky_q <= 1'b1;
			if (state_q == ST_MUL3 && m0_done) begin
				acc_x_q <= nx.val;
				acc_y_q <= ny.val;
				acc_h_q <= nh.val;
				if (nx.ovf || ny.ovf || nh.ovf)
					sticky_q <= 1'b1;
			end
			// drop a taken pose, publish a new one
			if (out_valid && !out_stall)
				ovalid_q <= 1'b0;
			if (state_q == ST_PUB && (!ovalid_q || !out_stall)) begin
				ovalid_q <= 1'b1;
				osat_q   <= sticky_q;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept && !first)
			time_q <= sample_time;
		if (state_q == ST_MUL1 && m0_done)
			dc_q <= dc_sat;
		if (state_q == ST_MUL2 && m0_done) begin
			dth_q  <= dth_s.val;
			mneg_q <= mid[32];
			rem_q  <= mid[32] ? 33'(-mid) : 33'(mid);
			k_q    <= 4'd9;
		end
		if (state_q == ST_MOD) begin
			if (rem_q >= sub_k)
				rem_q <= rem_q - sub_k;
			k_q <= k_q - 4'd1;
		end
		if (state_q == ST_FOLD) begin
			cneg_q <= fneg;
			z_q    <= 34'(r2) <<< 10;
			x_q    <= CORDIC_GAIN;
			y_q    <= '0;
			i_q    <= '0;
		end
		if (state_q == ST_CORD && !last_step) begin
			i_q <= i_q + 1'b1;
			if (!z_q[33]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
		if (state_q == ST_PUB && (!ovalid_q || !out_stall)) begin
			otime_q <= time_q;
			ox_q    <= acc_x_q;
			oy_q    <= acc_y_q;
			oh_q    <= acc_h_q;
		end
	end

	assign out_valid = ovalid_q;
	assign pose_time = otime_q;
	assign pos_x     = ox_q;
	assign pos_y     = oy_q;
	assign heading   = oh_q;
	assign saturated = osat_q;
endmodule
`default_nettype wire

FILE: src/ddo_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module ddo_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_stall,
	input wire        out_valid,
	input wire        out_stall,
	input wire [31:0] pos_x,
	input wire [31:0] heading,
	input wire        saturated
);
	// hold a stalled pose
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pos_x) && $stable(heading))
		else $error("stalled pose changed");

	// keep the saturation flag sticky
	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |=> saturated)
		else $error("saturation flag cleared");

	// busy only after an item was taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid))
		else $error("busy without an item");

	// change the pose only when the output register is free
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(pos_x) |-> $past(!out_valid || !out_stall))
		else $error("pose overwritten while waiting");
endmodule

bind differential_drive_odometry ddo_checker u_ddo_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .pos_x(pos_x),
	.heading(heading), .saturated(saturated)
);
`default_nettype wire

FILE: bench/differential_drive_odometry_test.sv
`timescale 1ns / 1ps
module differential_drive_odometry_test;
	import ddo_pkg::*;

	localparam int STEPS = 24;
	localparam int IDLE_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 200;
	// index past the register list, ignored by the block
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [31:0] stamp;
		logic [31:0] fl;
		logic [31:0] fr;
		logic [31:0] rl;
		logic [31:0] rr;
	} wheel_sample_t;

	typedef struct packed {
		logic [31:0] stamp;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] hdg;
		logic        sat;
	} pose_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [31:0] sample_time = '0;
	logic signed [31:0] front_left_count = '0;
	logic signed [31:0] front_right_count = '0;
	logic signed [31:0] rear_left_count = '0;
	logic signed [31:0] rear_right_count = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [31:0] pose_time;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] heading;
	logic saturated;

	differential_drive_odometry #(.CORDIC_STEPS(STEPS)) DUT (.*);

	always #6 clk = ~clk;

	wheel_sample_t pending_samples[$];
	pose_t expected_poses[$];
	int errors = 0;
	int samples_taken = 0;
	int poses_checked = 0;
	int config_writes = 0;

	// predictor state
	logic [31:0] mpt_q = MPT_RESET;
	logic [23:0] iwb_q = IWB_RESET;
	logic [31:0] last_counts[4] = '{default: '0};
	logic primed = 1'b0;
	logic signed [31:0] odo_x = '0, odo_y = '0, odo_hdg = '0;
	logic odo_sat = 1'b0;

	longint atan_steps[32] = '{
		843314856, 497837829, 263043836, 133525158, 67021686, 33543515, 16775850,
		8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071, 65535, 32767,
		16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31, 15, 8, 4, 2, 1, 0};

	function automatic longint clamp_sat(longint v, longint lo, longint hi);
		if (v < lo) begin
			odo_sat = 1'b1;
			return lo;
		end
		if (v > hi) begin
			odo_sat = 1'b1;
			return hi;
		end
		return v;
	endfunction

	// rotate a gain-compensated unit vector to the angle, Q.20 in, Q.30 out
	function automatic void rotate_unit(longint ang, output longint c, output longint s);
		longint r, cx, cy, z, xs, ys;
		bit flip;
		r = ang % longint'(TWO_PI_Q20);
		flip = 1'b0;
		cx = longint'(CORDIC_GAIN);
		cy = 0;
		if (r > longint'(PI_Q20)) r -= longint'(TWO_PI_Q20);
		if (r < -longint'(PI_Q20)) r += longint'(TWO_PI_Q20);
		if (r > longint'(HALF_PI_Q20)) begin
			r -= longint'(PI_Q20);
			flip = 1'b1;
		end else if (r < -longint'(HALF_PI_Q20)) begin
			r += longint'(PI_Q20);
			flip = 1'b1;
		end
		z = r * 1024;
		for (int i = 0; i < STEPS && i < 32; i++) begin
			xs = cx >>> i;
			ys = cy >>> i;
			if (z >= 0) begin
				cx -= ys; cy += xs; z -= atan_steps[i];
			end else begin
				cx += ys; cy -= xs; z += atan_steps[i];
			end
		end
		c = flip ? -cx : cx;
		s = flip ? -cy : cy;
	endfunction

	function automatic longint side_metres(longint front, longint rear);
		longint ticks;
		ticks = (front + rear) / 2;
		return (ticks * longint'({32'b0, mpt_q}) + 32768) >>> 16;
	endfunction

	// advance the pose for one accepted sample, queue the expected pose
	function automatic void advance_pose(wheel_sample_t smp);
		logic [31:0] now[4];
		longint d[4];
		longint lm, rm, dc, diff, dth, mid, c, s, dx, dy;
		now = '{smp.fl, smp.fr, smp.rl, smp.rr};
		if (!primed) begin
			last_counts = now;
			primed = 1'b1;
			return;
		end
		for (int k = 0; k < 4; k++) begin
			d[k] = longint'($signed(now[k] - last_counts[k]));
		end
		last_counts = now;
		lm = side_metres(d[0], d[2]);
		rm = side_metres(d[1], d[3]);
		dc = clamp_sat((lm + rm) >>> 1, -64'sd4294967296, 64'sd4294967296);
		diff = clamp_sat(rm - lm, -64'sd274877906944, 64'sd274877906944);
		dth = (diff * longint'({40'b0, iwb_q}) + 2048) >>> 12;
		dth = clamp_sat(dth, -64'sd2147483648, 64'sd2147483647);
		mid = longint'(odo_hdg) + (dth >>> 1);
		rotate_unit(mid, c, s);
		dx = (dc * c + 536870912) >>> 30;
		dy = (dc * s + 536870912) >>> 30;
		odo_x = 32'(clamp_sat(longint'(odo_x) + dx, -64'sd2147483648, 64'sd2147483647));
		odo_y = 32'(clamp_sat(longint'(odo_y) + dy, -64'sd2147483648, 64'sd2147483647));
		odo_hdg = 32'(clamp_sat(longint'(odo_hdg) + dth, -64'sd2147483648,
			64'sd2147483647));
		expected_poses.push_back('{smp.stamp, odo_x, odo_y, odo_hdg, odo_sat});
	endfunction

	// mostly short gaps, a few long, none at all while calm
	function automatic int pick_gap(bit calm);
		int r;
		r = $urandom_range(0, 19);
		if (calm || r < 12) return 0;
		if (r < 19) return $urandom_range(1, 4);
		return $urandom_range(20, 300);
	endfunction

	// drive samples
	int in_gap = 0;
	int in_calm_cnt = 0;
	bit in_calm = 1'b0;
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			advance_pose('{sample_time, front_left_count, front_right_count,
				rear_left_count, rear_right_count});
			samples_taken++;
		end
		if (in_calm_cnt == 0) begin
			in_calm <= ($urandom_range(0, 3) == 0);
			in_calm_cnt <= $urandom_range(50, 400);
		end else begin
			in_calm_cnt <= in_calm_cnt - 1;
		end
		if (!in_valid || !in_stall) begin
			if (in_gap > 0) begin
				in_gap <= in_gap - 1;
				in_valid <= 1'b0;
			end else if (arst_n && pending_samples.size() > 0) begin
				wheel_sample_t smp;
				smp = pending_samples.pop_front();
				sample_time <= smp.stamp;
				front_left_count <= smp.fl;
				front_right_count <= smp.fr;
				rear_left_count <= smp.rl;
				rear_right_count <= smp.rr;
				in_valid <= 1'b1;
				in_gap <= pick_gap(in_calm);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// check poses, stall at random, watch for a hang
	int out_gap = 0;
	int idle_cycles = 0;
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (expected_poses.size() == 0) begin
				$error("pose with none expected: time %0d", pose_time);
				errors++;
			end else begin
				pose_t want;
				want = expected_poses.pop_front();
				if (pose_time !== want.stamp) begin
					$error("pose_time: expected %0d, got %0d", want.stamp, pose_time);
					errors++;
				end
				if (pos_x !== want.x) begin
					$error("pos_x: expected %0d, got %0d", $signed(want.x), pos_x);
					errors++;
				end
				if (pos_y !== want.y) begin
					$error("pos_y: expected %0d, got %0d", $signed(want.y), pos_y);
					errors++;
				end
				if (heading !== want.hdg) begin
					$error("heading: expected %0d, got %0d", $signed(want.hdg), heading);
					errors++;
				end
				if (saturated !== want.sat) begin
					$error("saturated: expected %0b, got %0b", want.sat, saturated);
					errors++;
				end
			end
			poses_checked++;
		end
		if (out_gap > 0) begin
			out_gap <= out_gap - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			out_gap <= pick_gap(in_calm);
		end
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: %0d samples pending, %0d poses expected",
				pending_samples.size(), expected_poses.size());
			$display("** differential_drive_odometry: FAILED **");
			$finish;
		end
	end

	logic [31:0] wheel[4] = '{default: '0};

	task automatic queue_counts(logic [31:0] a, logic [31:0] b, logic [31:0] c,
		logic [31:0] d);
		wheel = '{a, b, c, d};
		pending_samples.push_back('{$urandom, a, b, c, d});
	endtask

	task automatic queue_step(int dl, int dr, int rear_skew);
		queue_counts(wheel[0] + dl, wheel[1] + dr, wheel[2] + dl + rear_skew,
			wheel[3] + dr - rear_skew);
	endtask

	// let the block drain before touching the registers
	task automatic wait_drained();
		while (pending_samples.size() > 0 || in_valid || expected_poses.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == REG_MPT) mpt_q = val;
		else if (idx == REG_IWB) iwb_q = val[23:0];
		config_writes++;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_random(int n);
		int kind, span;
		for (int i = 0; i < n; i++) begin
			kind = $urandom_range(0, 19);
			span = ($urandom_range(0, 7) == 0) ? 200000 : 2000;
			if (kind < 16) begin
				queue_step($urandom_range(0, 2 * span) - span,
					$urandom_range(0, 2 * span) - span, $urandom_range(0, 6) - 3);
			end else if (kind < 18) begin
				queue_step($urandom, $urandom, $urandom);
			end else begin
				queue_counts($urandom, $urandom, $urandom, $urandom);
			end
		end
	endtask

	logic [31:0] mpt_set[6] = '{32'd1, 32'hffffffff, 32'd7906071, 32'd65536,
		32'd40000000, 32'd1 << 31};
	logic [31:0] iwb_set[6] = '{32'd1, 32'h00ffffff, 32'd1 << 20, 32'd65536,
		32'd300000, 32'd1};

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first sample only primes the counts; then zero motion, truncation,
		// extremes of the delta and spins that fold the mid-step heading
		queue_counts(32'h7fffffff, 32'h80000000, 32'hffffffff, 32'd0);
		queue_step(0, 0, 0);
		queue_counts(wheel[0] + 1, wheel[1] - 1, wheel[2], wheel[3]);
		queue_counts(wheel[0] - 1, wheel[1] + 1, wheel[2], wheel[3]);
		for (int k = 0; k < 4; k++) queue_step(-5000, 5000, 0);
		for (int k = 0; k < 4; k++) queue_step(3000, 3000, 0);
		queue_step(32'h7fffffff, 32'h7fffffff, 0);
		queue_step(32'h80000000, 32'h80000000, 0);
		queue_step(32'h7fffffff, 32'h80000000, 0);
		queue_step(32'h80000000, 32'h7fffffff, 0);
		queue_counts(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
		queue_counts(32'd0, 32'd0, 32'd0, 32'd0);
		for (int k = 0; k < 4; k++) queue_step(-200000, 200000, 1);
		queue_random(180);

		for (int p = 0; p < 6; p++) begin
			wait_drained();
			write_reg(REG_MPT, mpt_set[p]);
			write_reg(REG_IWB, iwb_set[p]);
			if (p == 3) write_reg(REG_UNUSED, $urandom);
			queue_random(200);
		end
		wait_drained();
		write_reg(REG_MPT, $urandom_range(1000, 1 << 26));
		write_reg(REG_IWB, $urandom_range(1, 24'hffffff));
		queue_random(60);
		wait_drained();

		$display("covered %0d samples, %0d poses checked, %0d register writes",
			samples_taken, poses_checked, config_writes);
		$display("settings ranged from the smallest to the largest scale and wheelbase");
		if (errors == 0)
			$display("** differential_drive_odometry: PASSED **");
		else
			$display("** differential_drive_odometry: FAILED **");
		$finish;
	end

endmodule
